// ===== src/spg_pkg.sv =====
// spg_pkg: shared types and constants for the step/direction pulse generator
// no dependencies; imported by stepper_pulse_gen_limit_switch_top and tb_top
`timescale 1ns / 1ps
`default_nettype none

package spg_pkg;

	localparam int unsigned PERIOD_W = 16;
	localparam int unsigned COUNT_W  = 24;
	localparam int unsigned TOTAL_W  = 32;

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1250;
	localparam logic [COUNT_W-1:0]  COUNT_MAX    = {COUNT_W{1'b1}};

	typedef enum logic [1:0] {
		OP_TICK       = 2'd0,
		OP_MOVE_LEFT  = 2'd1,
		OP_MOVE_RIGHT = 2'd2,
		OP_STOP       = 2'd3
	} op_t;

	// one result item
	typedef struct packed {
		logic               dir_pin;
		logic               step_pin;
		logic               busy_res;
		logic               move_done;
		logic               limit_hit;
		logic               rejected;
		logic [COUNT_W-1:0] steps_since_limit;
		logic [TOTAL_W-1:0] limit_total;
	} result_t;

endpackage

`default_nettype wire

// ===== src/stepper_pulse_gen_limit_switch_top.sv =====
// Step/direction pulse generator for a stepper motor with two limit switches.
// Every transfer on the input channel is one command (tick, move left, move right, stop) and
// gives exactly one result transfer. The block takes one command per clock while the output
// is not stalled: the command is registered in the input register, processed against the
// motion state, and its result lands in an output register, from which it is presented.
// in_ready follows out_ready combinationally when both the input and the output register
// hold a command. The half-period register is written by cfg_we/cfg_wdata; a value of zero
// acts as one.
// Depends on spg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stepper_pulse_gen_limit_switch_top (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cfg_we,
	input  wire  [spg_pkg::PERIOD_W-1:0]  cfg_wdata,
	input  wire                           in_valid,
	output logic                          in_ready,
	input  wire  [1:0]                    opcode,
	input  wire  [spg_pkg::COUNT_W-1:0]   half_steps,
	input  wire                           limit_left,
	input  wire                           limit_right,
	output logic                          out_valid,
	input  wire                           out_ready,
	output logic                          dir_pin,
	output logic                          step_pin,
	output logic                          busy_res,
	output logic                          move_done,
	output logic                          limit_hit,
	output logic                          rejected,
	output logic [spg_pkg::COUNT_W-1:0]   steps_since_limit,
	output logic [spg_pkg::TOTAL_W-1:0]   limit_total
);
	import spg_pkg::*;

	// configuration and motion state
	logic [PERIOD_W-1:0] half_period_q;
	logic [PERIOD_W-1:0] tick_div_q;
	logic [COUNT_W-1:0]  remaining_q;
	logic                travel_left_q;
	logic                toggle_q;
	logic                step_q;
	logic [COUNT_W-1:0]  step_cnt_q;
	logic [TOTAL_W-1:0]  limit_sum_q;
	logic                moving_q;
	logic                dir_q;

	// input stage
	logic                valid_s1;
	op_t                 op_s1;
	logic [COUNT_W-1:0]  count_s1;
	logic                sw_left_s1;
	logic                sw_right_s1;

	// result stage
	logic                valid_s2;
	result_t             res_s2;

	logic advance;

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	// next-state logic for the registered command
	logic [PERIOD_W-1:0] period;
	logic [PERIOD_W:0]   div_inc;
	logic                event_hit;
	logic                sw_ahead;

	logic [PERIOD_W-1:0] tick_div_d;
	logic [COUNT_W-1:0]  remaining_d;
	logic                travel_left_d;
	logic                toggle_d;
	logic                step_d;
	logic [COUNT_W-1:0]  step_cnt_d;
	logic [TOTAL_W-1:0]  limit_sum_d;
	logic                moving_d;
	logic                dir_d;
	logic                done_d;
	logic                hit_d;
	logic                rej_d;

	assign period    = (half_period_q == '0) ? PERIOD_W'(1) : half_period_q;
	assign div_inc   = {1'b0, tick_div_q} + (PERIOD_W+1)'(1);
	assign event_hit = div_inc >= {1'b0, period};
	assign sw_ahead  = travel_left_q ? sw_left_s1 : sw_right_s1;

	always_comb begin
		tick_div_d    = tick_div_q;
		remaining_d   = remaining_q;
		travel_left_d = travel_left_q;
		toggle_d      = toggle_q;
		step_d        = step_q;
		step_cnt_d    = step_cnt_q;
		limit_sum_d   = limit_sum_q;
		moving_d      = moving_q;
		dir_d         = dir_q;
		done_d        = 1'b0;
		hit_d         = 1'b0;
		rej_d         = 1'b0;
		unique case (op_s1) inside
			OP_TICK: begin
				if (moving_q) begin
					if (event_hit) begin
						tick_div_d = '0;
						if (remaining_q != '0) begin
							remaining_d = remaining_q - COUNT_W'(1);
							dir_d       = travel_left_q;
							if (sw_ahead) begin
								// switch in the direction of travel: reverse the travel direction and end the move
								travel_left_d = !travel_left_q;
								limit_sum_d   = limit_sum_q + TOTAL_W'(step_cnt_q);
								step_cnt_d    = '0;
								step_d        = 1'b0;
								moving_d      = 1'b0;
								done_d        = 1'b1;
								hit_d         = 1'b1;
							end else begin
								step_d   = toggle_q;
								toggle_d = !toggle_q;
								if (step_cnt_q != COUNT_MAX) begin
									step_cnt_d = step_cnt_q + COUNT_W'(1);
								end
							end
						end else begin
							moving_d = 1'b0;
							done_d   = 1'b1;
						end
					end else begin
						tick_div_d = div_inc[PERIOD_W-1:0];
					end
				end
			end
			OP_STOP: begin
				step_d = 1'b0;
				if (moving_q) begin
					moving_d = 1'b0;
					done_d   = 1'b1;
				end
			end
			OP_MOVE_LEFT, OP_MOVE_RIGHT: begin
				if (moving_q) begin
					rej_d = 1'b1;
				end else begin
					travel_left_d = (op_s1 == OP_MOVE_LEFT);
					remaining_d   = count_s1;
					tick_div_d    = '0;
					moving_d      = 1'b1;
				end
			end
			default: begin
				moving_d = moving_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= PERIOD_RESET;
		end else if (cfg_we) begin
			half_period_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_div_q    <= '0;
			remaining_q   <= '0;
			travel_left_q <= 1'b0;
			toggle_q      <= 1'b0;
			step_q        <= 1'b0;
			step_cnt_q    <= '0;
			limit_sum_q   <= '0;
			moving_q      <= 1'b0;
			dir_q         <= 1'b0;
		end else if (advance) begin
			tick_div_q    <= tick_div_d;
			remaining_q   <= remaining_d;
			travel_left_q <= travel_left_d;
			toggle_q      <= toggle_d;
			step_q        <= step_d;
			step_cnt_q    <= step_cnt_d;
			limit_sum_q   <= limit_sum_d;
			moving_q      <= moving_d;
			dir_q         <= dir_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1       <= op_t'(opcode);
			count_s1    <= half_steps;
			sw_left_s1  <= limit_left;
			sw_right_s1 <= limit_right;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2.dir_pin           <= dir_d;
			res_s2.step_pin          <= step_d;
			res_s2.busy_res          <= moving_d;
			res_s2.move_done         <= done_d;
			res_s2.limit_hit         <= hit_d;
			res_s2.rejected          <= rej_d;
			res_s2.steps_since_limit <= step_cnt_d;
			res_s2.limit_total       <= limit_sum_d;
		end
	end

	assign out_valid         = valid_s2;
	assign dir_pin           = res_s2.dir_pin;
	assign step_pin          = res_s2.step_pin;
	assign busy_res          = res_s2.busy_res;
	assign move_done         = res_s2.move_done;
	assign limit_hit         = res_s2.limit_hit;
	assign rejected          = res_s2.rejected;
	assign steps_since_limit = res_s2.steps_since_limit;
	assign limit_total       = res_s2.limit_total;

`ifndef SYNTHESIS
	// a limit hit always ends the move and clears the step count
	a_hit_ends_move: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && limit_hit |-> move_done && !busy_res && steps_since_limit == '0
		&& !step_pin)
		else $error("limit hit without move end");

	// a rejected move leaves the running move in place
	a_reject_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rejected |-> busy_res && !move_done)
		else $error("reject while idle");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && move_done |-> !busy_res)
		else $error("move done but still busy");

	// reported busy state matches the state register
	a_busy_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> res_s2.busy_res == moving_q)
		else $error("busy result out of step with state");

	// a stalled result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !out_ready |-> !advance)
		else $error("result register overwritten");
`endif

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// tb_top: self-checking testbench for stepper_pulse_gen_limit_switch_top
// directed command table, then random move/tick/stop traffic with gaps and output stalls
// depends on spg_pkg and the top-level RTL
`timescale 1ns / 1ps

module tb_top;
	import spg_pkg::*;

	localparam int unsigned CLK_HALF     = 4;
	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned PHASE_ITEMS  = 95;
	localparam int unsigned NUM_PHASES   = 6;
	localparam int unsigned DRAIN_CYCLES = 8;

	// expectations that can be read straight off the command
	localparam result_t RES_IDLE = '0;
	localparam result_t RES_BUSY = {1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 24'd0, 32'd0};
	localparam result_t RES_REJ  = {1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 24'd0, 32'd0};

	typedef struct packed {
		logic               is_cfg;
		op_t                op;
		logic [COUNT_W-1:0] hs;
		logic               ll;
		logic               lr;
		logic               typed;
		result_t            res;
	} cmd_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [PERIOD_W-1:0] cfg_wdata = '0;
	logic                in_valid = 1'b0;
	logic [1:0]          opcode = '0;
	logic [COUNT_W-1:0]  half_steps = '0;
	logic                limit_left = 1'b0;
	logic                limit_right = 1'b0;
	logic                out_ready = 1'b0;
	wire                 in_ready;
	wire                 out_valid;
	wire                 dir_pin;
	wire                 step_pin;
	wire                 busy_res;
	wire                 move_done;
	wire                 limit_hit;
	wire                 rejected;
	wire [COUNT_W-1:0]   steps_since_limit;
	wire [TOTAL_W-1:0]   limit_total;

	// motion state as the block should hold it
	logic [PERIOD_W-1:0] per_cfg = PERIOD_RESET;
	logic [PERIOD_W-1:0] div_cnt = '0;
	logic [COUNT_W-1:0]  half_left = '0;
	logic                go_left = 1'b0;
	logic                toggle_lvl = 1'b0;
	logic                step_lvl = 1'b0;
	logic                dir_lvl = 1'b0;
	logic [COUNT_W-1:0]  step_cnt = '0;
	logic [TOTAL_W-1:0]  total_acc = '0;
	logic                in_motion = 1'b0;

	cmd_row_t    sent_q[$];
	result_t     want_q[$];
	int unsigned err_cnt = 0;
	int unsigned live_cnt = 0;
	int unsigned checked_cnt = 0;
	int unsigned done_cnt = 0;
	int unsigned hit_cnt = 0;
	int unsigned rej_cnt = 0;
	int unsigned cycle_cnt = 0;
	int unsigned stall_left = 0;
	logic        idle_en = 1'b1;

	stepper_pulse_gen_limit_switch_top u_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_wdata         (cfg_wdata),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.opcode            (opcode),
		.half_steps        (half_steps),
		.limit_left        (limit_left),
		.limit_right       (limit_right),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.dir_pin           (dir_pin),
		.step_pin          (step_pin),
		.busy_res          (busy_res),
		.move_done         (move_done),
		.limit_hit         (limit_hit),
		.rejected          (rejected),
		.steps_since_limit (steps_since_limit),
		.limit_total       (limit_total)
	);

	always #(CLK_HALF) clk = ~clk;

	function automatic result_t motor_step(input op_t op, input logic [COUNT_W-1:0] hs,
			input logic ll, input logic lr);
		result_t            r;
		logic [PERIOD_W:0]  eff_per;
		logic [PERIOD_W:0]  div_next;
		r = '0;
		case (op)
			OP_TICK: begin
				if (in_motion) begin
					eff_per = (per_cfg == '0) ? (PERIOD_W+1)'(1) : {1'b0, per_cfg};
					div_next = {1'b0, div_cnt} + 1'b1;
					if (div_next >= eff_per) begin
						div_cnt = '0;
						if (half_left != '0) begin
							half_left = half_left - 1'b1;
							dir_lvl = go_left;
							if ((ll && go_left) || (lr && !go_left)) begin
								// switch ahead: turn around and bank the step count
								go_left = ~go_left;
								total_acc = total_acc + TOTAL_W'(step_cnt);
								step_cnt = '0;
								step_lvl = 1'b0;
								in_motion = 1'b0;
								r.move_done = 1'b1;
								r.limit_hit = 1'b1;
							end else begin
								step_lvl = toggle_lvl;
								toggle_lvl = ~toggle_lvl;
								if (step_cnt != COUNT_MAX)
									step_cnt = step_cnt + 1'b1;
							end
						end else begin
							// event with nothing left ends the move
							in_motion = 1'b0;
							r.move_done = 1'b1;
						end
					end else
						div_cnt = div_next[PERIOD_W-1:0];
				end
			end
			OP_STOP: begin
				step_lvl = 1'b0;
				if (in_motion) begin
					in_motion = 1'b0;
					r.move_done = 1'b1;
				end
			end
			default: begin
				if (in_motion)
					r.rejected = 1'b1;
				else begin
					go_left = (op == OP_MOVE_LEFT);
					half_left = hs;
					div_cnt = '0;
					in_motion = 1'b1;
				end
			end
		endcase
		r.dir_pin = dir_lvl;
		r.step_pin = step_lvl;
		r.busy_res = in_motion;
		r.steps_since_limit = step_cnt;
		r.limit_total = total_acc;
		return r;
	endfunction

	function automatic cmd_row_t mk_row(input op_t op, input logic [COUNT_W-1:0] hs,
			input logic ll, input logic lr, input logic typed, input result_t res);
		cmd_row_t row;
		row.is_cfg = 1'b0;
		row.op = op;
		row.hs = hs;
		row.ll = ll;
		row.lr = lr;
		row.typed = typed;
		row.res = res;
		return row;
	endfunction

	function automatic cmd_row_t mk_cfg(input logic [PERIOD_W-1:0] val);
		cmd_row_t row;
		row = '0;
		row.is_cfg = 1'b1;
		row.hs = COUNT_W'(val);
		return row;
	endfunction

	// mostly ticks so moves run their course; short counts with the odd huge one
	function automatic cmd_row_t rand_row();
		int unsigned        pick;
		op_t                op;
		logic [COUNT_W-1:0] hs;
		pick = $urandom_range(0, 99);
		if (pick < 80)
			op = OP_TICK;
		else if (pick < 88)
			op = OP_MOVE_LEFT;
		else if (pick < 96)
			op = OP_MOVE_RIGHT;
		else
			op = OP_STOP;
		if ($urandom_range(0, 6) == 0)
			hs = COUNT_W'($urandom);
		else
			hs = COUNT_W'($urandom_range(0, 24));
		return mk_row(op, hs, $urandom_range(0, 24) == 0, $urandom_range(0, 24) == 0,
			1'b0, RES_IDLE);
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
			err_cnt++;
		end
	endtask

	task automatic send_row(input cmd_row_t row);
		sent_q.push_back(row);
		in_valid <= 1'b1;
		opcode <= row.op;
		half_steps <= row.hs;
		limit_left <= row.ll;
		limit_right <= row.lr;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (want_q.size() != 0 || sent_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_period(input logic [PERIOD_W-1:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		per_cfg = val;
	endtask

	// input transfers feed the model, output transfers are checked against it
	always @(posedge clk) begin : monitor
		cmd_row_t row;
		result_t  want;
		if (arst_n && in_valid && in_ready) begin
			row = sent_q.pop_front();
			if (op_t'(opcode) != OP_TICK || in_motion)
				live_cnt++;
			want = motor_step(op_t'(opcode), half_steps, limit_left, limit_right);
			done_cnt += want.move_done;
			hit_cnt += want.limit_hit;
			rej_cnt += want.rejected;
			want_q.push_back(row.typed ? row.res : want);
		end
		if (arst_n && out_valid && out_ready) begin
			if (want_q.size() == 0) begin
				$display("%0t: result transfer with nothing expected, actual steps 0x%0h",
					$time, steps_since_limit);
				err_cnt++;
			end else begin
				want = want_q.pop_front();
				check_field("dir_pin", 32'(want.dir_pin), 32'(dir_pin));
				check_field("step_pin", 32'(want.step_pin), 32'(step_pin));
				check_field("busy_res", 32'(want.busy_res), 32'(busy_res));
				check_field("move_done", 32'(want.move_done), 32'(move_done));
				check_field("limit_hit", 32'(want.limit_hit), 32'(limit_hit));
				check_field("rejected", 32'(want.rejected), 32'(rejected));
				check_field("steps_since_limit", 32'(want.steps_since_limit),
					32'(steps_since_limit));
				check_field("limit_total", want.limit_total, limit_total);
				checked_cnt++;
			end
		end
	end

	always @(posedge clk) begin
		if (!idle_en)
			out_ready <= 1'b1;
		else if (stall_left != 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 7) == 0) begin
			out_ready <= 1'b0;
			stall_left <= $urandom_range(0, 6);
		end else
			out_ready <= 1'b1;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
			$display("Verification failed");
			$finish;
		end
	end

	initial begin : stimulus
		cmd_row_t            dir_rows[$];
		logic [PERIOD_W-1:0] per_val;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// idle commands out of reset, switches and count ignored
		dir_rows.push_back(mk_row(OP_TICK, 24'd0, 1'b0, 1'b0, 1'b1, RES_IDLE));
		dir_rows.push_back(mk_row(OP_STOP, COUNT_MAX, 1'b1, 1'b1, 1'b1, RES_IDLE));
		// zero period behaves as an event every tick
		dir_rows.push_back(mk_cfg(16'd0));
		dir_rows.push_back(mk_row(OP_MOVE_RIGHT, 24'd3, 1'b0, 1'b0, 1'b1, RES_BUSY));
		dir_rows.push_back(mk_row(OP_MOVE_LEFT, 24'd5, 1'b0, 1'b0, 1'b1, RES_REJ));
		// left switch does not matter while traveling right
		dir_rows.push_back(mk_row(OP_TICK, 24'd0, 1'b1, 1'b0, 1'b0, RES_IDLE));
		dir_rows.push_back(mk_row(OP_TICK, 24'd0, 1'b0, 1'b0, 1'b0, RES_IDLE));
		dir_rows.push_back(mk_row(OP_TICK, 24'd0, 1'b0, 1'b0, 1'b0, RES_IDLE));
		dir_rows.push_back(mk_row(OP_TICK, 24'd0, 1'b0, 1'b0, 1'b0, RES_IDLE));
		dir_rows.push_back(mk_row(OP_MOVE_LEFT, COUNT_MAX, 1'b0, 1'b0, 1'b0, RES_IDLE));
		dir_rows.push_back(mk_row(OP_TICK, 24'd0, 1'b0, 1'b1, 1'b0, RES_IDLE));
		dir_rows.push_back(mk_row(OP_TICK, 24'd0, 1'b1, 1'b0, 1'b0, RES_IDLE));
		// empty move ends at its first event
		dir_rows.push_back(mk_row(OP_MOVE_RIGHT, 24'd0, 1'b0, 1'b0, 1'b0, RES_IDLE));
		dir_rows.push_back(mk_row(OP_TICK, 24'd0, 1'b0, 1'b0, 1'b0, RES_IDLE));
		dir_rows.push_back(mk_row(OP_MOVE_RIGHT, 24'd10, 1'b0, 1'b0, 1'b0, RES_IDLE));
		dir_rows.push_back(mk_row(OP_TICK, 24'd0, 1'b1, 1'b1, 1'b0, RES_IDLE));
		dir_rows.push_back(mk_row(OP_STOP, 24'd0, 1'b0, 1'b0, 1'b0, RES_IDLE));
		dir_rows.push_back(mk_row(OP_MOVE_LEFT, 24'd4, 1'b0, 1'b0, 1'b0, RES_IDLE));
		dir_rows.push_back(mk_row(OP_TICK, 24'd0, 1'b0, 1'b0, 1'b0, RES_IDLE));
		dir_rows.push_back(mk_row(OP_STOP, 24'd0, 1'b0, 1'b0, 1'b0, RES_IDLE));
		// divider runs up under a long period, then the period drops below it
		dir_rows.push_back(mk_cfg(16'hFFFF));
		dir_rows.push_back(mk_row(OP_MOVE_LEFT, 24'd3, 1'b0, 1'b0, 1'b0, RES_IDLE));
		repeat (5)
			dir_rows.push_back(mk_row(OP_TICK, 24'd0, 1'b0, 1'b0, 1'b0, RES_IDLE));
		dir_rows.push_back(mk_cfg(16'd2));
		dir_rows.push_back(mk_row(OP_TICK, 24'd0, 1'b0, 1'b0, 1'b0, RES_IDLE));
		dir_rows.push_back(mk_row(OP_STOP, 24'd0, 1'b0, 1'b0, 1'b0, RES_IDLE));

		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg)
				write_period(dir_rows[i].hs[PERIOD_W-1:0]);
			else
				send_row(dir_rows[i]);
		end

		// moves may still be running when the period changes between phases
		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: per_val = 16'd1;
				1: per_val = PERIOD_W'($urandom_range(2, 6));
				2: per_val = 16'hFFFF;
				3: per_val = 16'd2;
				4: per_val = 16'd0;
				default: per_val = PERIOD_W'($urandom_range(1, 4));
			endcase
			write_period(per_val);
			idle_en = (p != 3) && (p != NUM_PHASES - 1);
			for (int k = 0; k < PHASE_ITEMS; k++)
				send_row(rand_row());
		end

		drain();
		$display("%0d results checked, %0d acting on motion; %0d moves ended, %0d at a limit",
			checked_cnt, live_cnt, done_cnt, hit_cnt);
		$display("%0d moves refused while busy; periods 0, 1, 2 and 65535 among those used",
			rej_cnt);
		if (err_cnt == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== sim.f =====
src/spg_pkg.sv
src/stepper_pulse_gen_limit_switch_top.sv
verif/tb_top.sv
